@@ rtl/bsdg_pkg.sv @@
// Package for the box signed distance and gradient unit.
// Holds field widths, axis codes, register indexes and pipeline side-band types.
// No dependencies.
package bsdg_pkg;

	localparam int P_W    = 32;  // point and centre coordinates
	localparam int H_W    = 31;  // half extents
	localparam int D_W    = 33;  // offset p - c
	localparam int Q_W    = 34;  // |d| - h, signed
	localparam int O_W    = 33;  // positive part of q
	localparam int O2_W   = 65;  // square of o
	localparam int S_W    = 66;  // sum of three squares
	localparam int R_W    = 33;  // integer square root of s
	localparam int DIST_W = 35;
	localparam int GRAD_W = 18;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_CENTER_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_HALF_X   = 3'd3;
	localparam logic [IDX_W-1:0] REG_HALF_Y   = 3'd4;
	localparam logic [IDX_W-1:0] REG_HALF_Z   = 3'd5;

	localparam int AXIS_W = 2;
	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	// Carried alongside the square-root row.
	typedef struct packed {
		logic [Q_W-1:0]             qk;
		logic [AXIS_W-1:0]          k;
		logic                       outside;
		logic [2:0]                 sgn;
		logic [S_W-1:0]             s;
		logic [2:0][O2_W-1:0]       o2;
	} sq_side_t;

	// Carried alongside the x gradient row.
	typedef struct packed {
		logic [Q_W-1:0]    qk;
		logic [AXIS_W-1:0] k;
		logic              outside;
		logic              sgn_x;
		logic [R_W-1:0]    root;
	} gx_side_t;

endpackage

@@ rtl/bsdg_cell.sv @@
// One bit cell of a restoring root or quotient row.
// Tests A + B*2^(BIT+1) + M*2^(2*BIT) against T and hands all data on. Uses no package.
module bsdg_cell #(
	parameter int AW  = 66,
	parameter int BW  = 33,
	parameter int MW  = 1,
	parameter int GW  = 33,
	parameter int SW  = 1,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid,
	input  logic [AW-1:0] t,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	input  logic [MW-1:0] m,
	input  logic [GW-1:0] g,
	input  logic [SW-1:0] side,
	output logic          valid_q,
	output logic [AW-1:0] t_q,
	output logic [AW-1:0] a_q,
	output logic [BW-1:0] b_q,
	output logic [MW-1:0] m_q,
	output logic [GW-1:0] g_q,
	output logic [SW-1:0] side_q
);

	localparam int XW = AW + 4;

	logic [XW-1:0] x;
	logic          ok;

	// With A = M*g^2 and B = M*g, x is M*(g + 2^BIT)^2.
	always_comb begin
		x  = XW'(a) + (XW'(b) << (BIT + 1)) + (XW'(m) << (2 * BIT));
		ok = (x <= XW'(t));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_q    <= t;
			m_q    <= m;
			side_q <= side;
			if (ok) begin
				a_q <= x[AW-1:0];
				b_q <= b + (BW'(m) << BIT);
				g_q <= g | (GW'(1) << BIT);
			end else begin
				a_q <= a;
				b_q <= b;
				g_q <= g;
			end
		end
	end

endmodule

@@ rtl/bsdg_chain.sv @@
// A row of bit cells that resolves NB result bits, most significant first.
// Depends on bsdg_cell.
module bsdg_chain #(
	parameter int NB = 33,
	parameter int AW = 66,
	parameter int BW = 33,
	parameter int MW = 1,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid,
	input  logic [AW-1:0] t,
	input  logic [MW-1:0] m,
	input  logic [SW-1:0] side,
	output logic          res_valid,
	output logic [NB-1:0] res_g,
	output logic [SW-1:0] res_side
);

	logic          va [NB+1];
	logic [AW-1:0] ta [NB+1];
	logic [AW-1:0] aa [NB+1];
	logic [BW-1:0] ba [NB+1];
	logic [MW-1:0] ma [NB+1];
	logic [NB-1:0] ga [NB+1];
	logic [SW-1:0] sa [NB+1];

	assign va[0] = valid;
	assign ta[0] = t;
	assign aa[0] = '0;
	assign ba[0] = '0;
	assign ma[0] = m;
	assign ga[0] = '0;
	assign sa[0] = side;

	for (genvar k = 0; k < NB; k++) begin : g_cell
		bsdg_cell #(
			.AW(AW), .BW(BW), .MW(MW), .GW(NB), .SW(SW), .BIT(NB - 1 - k)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid(va[k]), .t(ta[k]), .a(aa[k]), .b(ba[k]), .m(ma[k]),
			.g(ga[k]), .side(sa[k]),
			.valid_q(va[k+1]), .t_q(ta[k+1]), .a_q(aa[k+1]), .b_q(ba[k+1]),
			.m_q(ma[k+1]), .g_q(ga[k+1]), .side_q(sa[k+1])
		);
	end

	assign res_valid = va[NB];
	assign res_g     = ga[NB];
	assign res_side  = sa[NB];

endmodule

@@ rtl/box_signed_distance_gradient_unit.sv @@
// Box signed distance and unit gradient, one query point per transfer.
// A point passes through stages 1 to 4, the square-root row, the gradient rows and the output register.
// Throughput: one point per cycle; the whole pipeline halts only while a result waits.
// Depth is set by the 33-cell square-root row and the FRAC_BITS+1 cell gradient rows.
// Reset (arst_n low, asynchronous) empties the pipeline and restores the box registers.
// Depends on bsdg_pkg and bsdg_chain.
module box_signed_distance_gradient_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	// Query points. s_tdata fields from bit 0: point_x, point_y, point_z.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,
	// Results. m_tdata fields from bit 0: distance, grad_x, grad_y, grad_z, zero fill.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata
);

	localparam int NB_G = FRAC_BITS + 1;
	localparam int T_W  = bsdg_pkg::O2_W + 2 * FRAC_BITS;
	localparam int B_W  = bsdg_pkg::S_W + FRAC_BITS + 1;
	localparam int EW   = (NB_G > bsdg_pkg::GRAD_W) ? NB_G : bsdg_pkg::GRAD_W;
	localparam int SQ_SW = $bits(bsdg_pkg::sq_side_t);
	localparam int GX_SW = $bits(bsdg_pkg::gx_side_t);

	// Box registers. The user must change them only while the unit is idle, so every stage may read them; not enforced.
	logic [bsdg_pkg::P_W-1:0] center_q [3];
	logic [bsdg_pkg::H_W-1:0] half_q   [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				center_q[i] <= '0;
				half_q[i]   <= 31'd65536;
			end
		end else if (wr_en) begin
			case (wr_index)
				bsdg_pkg::REG_CENTER_X: center_q[0] <= wr_data;
				bsdg_pkg::REG_CENTER_Y: center_q[1] <= wr_data;
				bsdg_pkg::REG_CENTER_Z: center_q[2] <= wr_data;
				bsdg_pkg::REG_HALF_X:   half_q[0]   <= wr_data[30:0];
				bsdg_pkg::REG_HALF_Y:   half_q[1]   <= wr_data[30:0];
				bsdg_pkg::REG_HALF_Z:   half_q[2]   <= wr_data[30:0];
				default: ;
			endcase
		end
	end

	// Every stage moves together; the pipeline holds only when the output register is
	// full and the consumer does not take its transfer.
	logic en;
	logic out_valid_q;
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// Stage 1: offset from the centre.
	logic                     valid_s1;
	logic [bsdg_pkg::D_W-1:0] d_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= {s_tdata[32*i+31], s_tdata[32*i +: 32]}
					- {center_q[i][31], center_q[i]};
			end
		end
	end

	// Stage 2: distance past each face, q = |d| - h, and the sign of d.
	logic                     valid_s2;
	logic [bsdg_pkg::Q_W-1:0] q_s2 [3];
	logic [2:0]               sgn_s2;
	logic [bsdg_pkg::D_W-1:0] abs_d [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_d[i] = d_s1[i][bsdg_pkg::D_W-1] ? (~d_s1[i] + 1'b1) : d_s1[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				q_s2[i]   <= {1'b0, abs_d[i]} - {3'b000, half_q[i]};
				sgn_s2[i] <= d_s1[i][bsdg_pkg::D_W-1];
			end
		end
	end

	// Stage 3: positive part of q and its square.
	logic                      valid_s3;
	logic [bsdg_pkg::Q_W-1:0]  q_s3 [3];
	logic [2:0]                sgn_s3;
	logic [bsdg_pkg::O2_W-1:0] o2_s3 [3];
	logic                      out_s3;
	logic [bsdg_pkg::O_W-1:0]  o_c [3];
	logic [2:0]                pos_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pos_c[i] = ($signed(q_s2[i]) > 0);
			o_c[i]   = pos_c[i] ? q_s2[i][bsdg_pkg::O_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				o2_s3[i] <= bsdg_pkg::O2_W'(o_c[i]) * bsdg_pkg::O2_W'(o_c[i]);
				q_s3[i]  <= q_s2[i];
			end
			sgn_s3 <= sgn_s2;
			out_s3 <= |pos_c;
		end
	end

	// Stage 4: sum of squares, and the nearest face for a point inside the box.
	// Ties go to x before y, and to y before z.
	logic                  valid_s4;
	bsdg_pkg::sq_side_t    side_s4;
	logic [bsdg_pkg::AXIS_W-1:0] k_c;
	logic [bsdg_pkg::Q_W-1:0]    qk_c;

	always_comb begin
		k_c  = bsdg_pkg::AXIS_X;
		qk_c = q_s3[0];
		if ($signed(q_s3[1]) > $signed(qk_c)) begin
			k_c  = bsdg_pkg::AXIS_Y;
			qk_c = q_s3[1];
		end
		if ($signed(q_s3[2]) > $signed(qk_c)) begin
			k_c  = bsdg_pkg::AXIS_Z;
			qk_c = q_s3[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.qk      <= qk_c;
			side_s4.k       <= k_c;
			side_s4.outside <= out_s3;
			side_s4.sgn     <= sgn_s3;
			side_s4.s       <= bsdg_pkg::S_W'(o2_s3[0]) + bsdg_pkg::S_W'(o2_s3[1])
				+ bsdg_pkg::S_W'(o2_s3[2]);
			for (int i = 0; i < 3; i++) begin
				side_s4.o2[i] <= o2_s3[i];
			end
		end
	end

	// Square-root row: one cell per root bit, floor(sqrt(s)).
	logic                     sq_valid;
	logic [bsdg_pkg::R_W-1:0] sq_root;
	logic [SQ_SW-1:0]         sq_side_raw;
	bsdg_pkg::sq_side_t       sq_side;

	bsdg_chain #(
		.NB(bsdg_pkg::R_W), .AW(bsdg_pkg::S_W), .BW(bsdg_pkg::R_W), .MW(1), .SW(SQ_SW)
	) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(valid_s4), .t(side_s4.s), .m(1'b1), .side(side_s4),
		.res_valid(sq_valid), .res_g(sq_root), .res_side(sq_side_raw)
	);

	assign sq_side = bsdg_pkg::sq_side_t'(sq_side_raw);

	// Gradient rows: per axis the largest g with s*g^2 <= (o * 2^FRAC_BITS)^2.
	bsdg_pkg::gx_side_t gx_in;
	logic [GX_SW-1:0]   gx_out_raw;
	bsdg_pkg::gx_side_t gx_out;
	logic               g_valid;
	logic [NB_G-1:0]    g_mag [3];
	logic               sgn_y_out;
	logic               sgn_z_out;

	always_comb begin
		gx_in.qk      = sq_side.qk;
		gx_in.k       = sq_side.k;
		gx_in.outside = sq_side.outside;
		gx_in.sgn_x   = sq_side.sgn[0];
		gx_in.root    = sq_root;
	end

	bsdg_chain #(
		.NB(NB_G), .AW(T_W), .BW(B_W), .MW(bsdg_pkg::S_W), .SW(GX_SW)
	) u_grad_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(sq_valid), .t(T_W'(sq_side.o2[0]) << (2 * FRAC_BITS)), .m(sq_side.s),
		.side(gx_in),
		.res_valid(g_valid), .res_g(g_mag[0]), .res_side(gx_out_raw)
	);

	bsdg_chain #(
		.NB(NB_G), .AW(T_W), .BW(B_W), .MW(bsdg_pkg::S_W), .SW(1)
	) u_grad_y (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(sq_valid), .t(T_W'(sq_side.o2[1]) << (2 * FRAC_BITS)), .m(sq_side.s),
		.side(sq_side.sgn[1]),
		.res_valid(), .res_g(g_mag[1]), .res_side(sgn_y_out)
	);

	bsdg_chain #(
		.NB(NB_G), .AW(T_W), .BW(B_W), .MW(bsdg_pkg::S_W), .SW(1)
	) u_grad_z (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(sq_valid), .t(T_W'(sq_side.o2[2]) << (2 * FRAC_BITS)), .m(sq_side.s),
		.side(sq_side.sgn[2]),
		.res_valid(), .res_g(g_mag[2]), .res_side(sgn_z_out)
	);

	assign gx_out = bsdg_pkg::gx_side_t'(gx_out_raw);

	// Output stage. Outside the box the gradient comes from the rows; inside it is a unit
	// step along the nearest face. A zero offset counts as positive.
	logic [bsdg_pkg::DIST_W-1:0] dist_c;
	logic [bsdg_pkg::GRAD_W-1:0] grad_c [3];
	logic [EW-1:0]               one_e;
	logic [EW-1:0]               mag_e  [3];
	logic [EW-1:0]               sgd_e  [3];
	logic [2:0]                  sel;
	logic [2:0]                  sgn_o;

	always_comb begin
		one_e  = EW'(1) << FRAC_BITS;
		sel[0] = (gx_out.k == bsdg_pkg::AXIS_X);
		sel[1] = (gx_out.k == bsdg_pkg::AXIS_Y);
		sel[2] = (gx_out.k == bsdg_pkg::AXIS_Z);
		sgn_o  = {sgn_z_out, sgn_y_out, gx_out.sgn_x};
		if (gx_out.outside) begin
			dist_c = bsdg_pkg::DIST_W'(gx_out.root);
		end else begin
			dist_c = {gx_out.qk[bsdg_pkg::Q_W-1], gx_out.qk};
		end
		for (int i = 0; i < 3; i++) begin
			if (gx_out.outside) begin
				mag_e[i] = EW'(g_mag[i]);
			end else begin
				mag_e[i] = sel[i] ? one_e : '0;
			end
			sgd_e[i]  = sgn_o[i] ? (~mag_e[i] + 1'b1) : mag_e[i];
			grad_c[i] = sgd_e[i][bsdg_pkg::GRAD_W-1:0];
		end
	end

	logic [bsdg_pkg::DIST_W-1:0] distance_q;
	logic [bsdg_pkg::GRAD_W-1:0] grad_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= g_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			distance_q <= dist_c;
			for (int i = 0; i < 3; i++) begin
				grad_q[i] <= grad_c[i];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, grad_q[2], grad_q[1], grad_q[0], distance_q};

endmodule

@@ rtl/bsdg_checker.sv @@
// Port-level checker for the box signed distance and gradient unit, with its bind.
// Depends on box_signed_distance_gradient_unit.
module bsdg_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	logic [2:0] nz;
	assign nz = {m_tdata[88:71] != 18'd0, m_tdata[70:53] != 18'd0, m_tdata[52:35] != 18'd0};

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input held off without an output stall");

	a_inside_unit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34] |-> (FRAC_BITS > 17) || ($countones(nz) == 1))
		else $error("inside point without a single axis gradient");

endmodule

bind box_signed_distance_gradient_unit bsdg_checker #(.FRAC_BITS(FRAC_BITS)) u_bsdg_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
